[sv/bounded_list_add_remove_get_core_assert.svh]
// Assertion macros for the bounded list core.
`ifndef BOUNDED_LIST_ADD_REMOVE_GET_CORE_ASSERT_SVH
`define BOUNDED_LIST_ADD_REMOVE_GET_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLARG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLARG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/blarg_pkg.sv]
// Shared types and codes of the bounded list core.
package blarg_pkg;

    localparam int OP_W   = 2;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_GET    = 2'd2
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_ABSENT = 2'd2,
        STAT_RANGE  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_MATCH  = 4'b0010,
        S_PREFIX = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic match;
        logic prefix;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic prefix_done;
    } t_sts;

endpackage

[sv/bounded_list_add_remove_get_core.sv]
// Top level of the bounded list core with add, remove-by-value and get-by-index.
//
//   channel   valid     stall     payload
//   input     i_valid   o_stall   i_operation, i_value, i_index
//   output    o_valid   i_stall   o_status, o_data, o_entry_count
//
// Add, get and unused codes pass through accept, then commit to the result register.
// Remove passes through accept, one parallel compare over all cells,
// clog2(CAPACITY) prefix-OR levels that locate the first match, then commit and shift.
// Synchronous reset clears the held count and controller, not the cells or the output registers.
// A stalled result holds in the output register; the next item is accepted meanwhile and
// waits at commit until the result is taken.
`include "bounded_list_add_remove_get_core_assert.svh"

module bounded_list_add_remove_get_core #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [blarg_pkg::OP_W-1:0]      i_operation,
    input  logic [blarg_pkg::DATA_W-1:0]    i_value,
    input  logic [blarg_pkg::IDX_W-1:0]     i_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [blarg_pkg::STAT_W-1:0]    o_status,
    output logic [blarg_pkg::DATA_W-1:0]    o_data,
    output logic [blarg_pkg::CNT_W-1:0]     o_entry_count
);

    blarg_pkg::t_cmd w_cmd;
    blarg_pkg::t_sts w_sts;

    blarg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    blarg_dpath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_index       (i_index),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_entry_count (o_entry_count)
    );

    `BLARG_ASSERT_NXT(a_one_item_at_a_time, i_valid && !o_stall, o_stall, "second item accepted while busy")
    `BLARG_ASSERT_NOW(a_full_at_capacity, o_valid && (o_status == blarg_pkg::STAT_FULL), o_entry_count == blarg_pkg::CNT_W'(CAPACITY), "full status with count below capacity")
    `BLARG_ASSERT_NOW(a_error_no_data, o_valid && (o_status != blarg_pkg::STAT_OK), o_data == '0, "error result carries data")

endmodule

[sv/blarg_ctrl.sv]
// Controller state machine of the bounded list core.
module blarg_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [blarg_pkg::OP_W-1:0]    i_operation,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    input  blarg_pkg::t_sts               i_sts,
    output blarg_pkg::t_cmd               o_cmd
);

    blarg_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              w_out_free;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != blarg_pkg::S_IDLE);
    assign o_valid    = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            blarg_pkg::S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_operation == blarg_pkg::OP_REMOVE) begin
                        n_state = blarg_pkg::S_MATCH;
                    end else begin
                        n_state = blarg_pkg::S_COMMIT;
                    end
                end
            end
            blarg_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = blarg_pkg::S_PREFIX;
            end
            blarg_pkg::S_PREFIX: begin
                o_cmd.prefix = 1'b1;
                if (i_sts.prefix_done) begin
                    n_state = blarg_pkg::S_COMMIT;
                end
            end
            blarg_pkg::S_COMMIT: begin
                // hold the result until the output slot frees up
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = blarg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = blarg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blarg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[sv/blarg_dpath.sv]
// Datapath of the bounded list core: entry cells, match search and result registers.
module blarg_dpath #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  blarg_pkg::t_cmd                 i_cmd,
    output blarg_pkg::t_sts                 o_sts,
    input  logic [blarg_pkg::OP_W-1:0]      i_operation,
    input  logic [blarg_pkg::DATA_W-1:0]    i_value,
    input  logic [blarg_pkg::IDX_W-1:0]     i_index,
    output logic [blarg_pkg::STAT_W-1:0]    o_status,
    output logic [blarg_pkg::DATA_W-1:0]    o_data,
    output logic [blarg_pkg::CNT_W-1:0]     o_entry_count
);

    localparam int DW       = blarg_pkg::DATA_W;
    localparam int IW       = blarg_pkg::IDX_W;
    localparam int CW       = blarg_pkg::CNT_W;
    localparam int HELD_W   = $clog2(CAPACITY + 1);
    localparam int LEVELS   = $clog2(CAPACITY);
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int GET_SPAN = (CAPACITY < (1 << IW)) ? CAPACITY : (1 << IW);
    localparam int CMP_W    = (HELD_W > IW) ? HELD_W : IW;

    logic [VALUE_WIDTH-1:0]          r_cells [CAPACITY];
    logic [HELD_W-1:0]               r_held, n_held;
    logic [blarg_pkg::OP_W-1:0]      r_op;
    logic [VALUE_WIDTH-1:0]          r_value;
    logic [IW-1:0]                   r_index;
    logic [CAPACITY-1:0]             r_match;
    logic [LVL_W-1:0]                r_level;
    logic [blarg_pkg::STAT_W-1:0]    r_status, n_status;
    logic [DW-1:0]                   r_data, n_data;
    logic [CW-1:0]                   r_count;

    logic [VALUE_WIDTH-1:0]          w_get_word;
    logic                            w_full;
    logic                            w_found;
    logic                            w_in_range;

    assign w_full     = (r_held == HELD_W'(CAPACITY));
    // prefix OR leaves the top bit set when any held entry matched
    assign w_found    = r_match[CAPACITY-1];
    assign w_in_range = (CMP_W'(r_index) < CMP_W'(r_held));

    assign o_sts.prefix_done = (r_level == LVL_W'(LEVELS - 1));

    always_comb begin
        w_get_word = '0;
        for (int i = 0; i < GET_SPAN; i++) begin
            if (r_index == IW'(i)) begin
                w_get_word = r_cells[i];
            end
        end
    end

    always_comb begin
        n_held   = r_held;
        n_status = blarg_pkg::STAT_OK;
        n_data   = '0;
        case (r_op)
            blarg_pkg::OP_ADD: begin
                if (w_full) begin
                    n_status = blarg_pkg::STAT_FULL;
                end else begin
                    n_held = r_held + HELD_W'(1);
                end
            end
            blarg_pkg::OP_REMOVE: begin
                if (w_found) begin
                    n_held = r_held - HELD_W'(1);
                end else begin
                    n_status = blarg_pkg::STAT_ABSENT;
                end
            end
            blarg_pkg::OP_GET: begin
                if (w_in_range) begin
                    n_data = DW'(w_get_word);
                end else begin
                    n_status = blarg_pkg::STAT_RANGE;
                end
            end
            default: begin
                n_status = blarg_pkg::STAT_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_level <= '0;
        end else begin
            if (i_cmd.commit) begin
                r_held <= n_held;
            end
            if (i_cmd.match) begin
                r_level <= '0;
            end else if (i_cmd.prefix) begin
                r_level <= r_level + LVL_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_value <= VALUE_WIDTH'(i_value);
            r_index <= i_index;
        end
        if (i_cmd.match) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_match[i] <= (HELD_W'(i) < r_held) && (r_cells[i] == r_value);
            end
        end else if (i_cmd.prefix) begin
            // one parallel prefix-OR level; all levels mark cells at or above the first match
            r_match <= r_match | (r_match << (1 << r_level));
        end
        if (i_cmd.commit) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_count  <= CW'(n_held);
            if (r_op == blarg_pkg::OP_ADD && !w_full) begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (r_held == HELD_W'(i)) begin
                        r_cells[i] <= r_value;
                    end
                end
            end
            if (r_op == blarg_pkg::OP_REMOVE && w_found) begin
                // close the gap: cells from the first match upward take their upper neighbor
                for (int i = 0; i < CAPACITY - 1; i++) begin
                    if (r_match[i]) begin
                        r_cells[i] <= r_cells[i+1];
                    end
                end
            end
        end
    end

    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_entry_count = r_count;

endmodule
